/* hdl/mtob_pkg.sv */
package mtob_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned NumChan = 4;
  localparam int unsigned AlphaIdx = 3;
  localparam int unsigned InDataW = 72;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [ChanW-1:0] ChanMax = 8'hFF;
  localparam logic [ChanW-1:0] OpacityNone = 8'hFF;

  typedef enum logic {
    MODE_MASK = 1'b0,
    MODE_OVER = 1'b1
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TINT_RED   = 3'd0,
    CFG_TINT_GREEN = 3'd1,
    CFG_TINT_BLUE  = 3'd2,
    CFG_TINT_ALPHA = 3'd3,
    CFG_OPACITY    = 3'd4
  } cfg_idx_e;

  // Channel order: red, green, blue, alpha.
  typedef logic [NumChan-1:0][ChanW-1:0] pix_t;

  localparam pix_t TintReset = {8'd255, 8'd0, 8'd0, 8'd0};

  typedef struct packed {
    mode_e            mode;
    logic [ChanW-1:0] coverage;
    pix_t             src;
    pix_t             dst;
  } blend_req_t;

  typedef struct packed {
    pix_t pix;
    logic changed;
  } blend_res_t;

  // Maps a byte 0..255 to a blend factor 0..256.
  function automatic logic [ChanW:0] expand_alpha(input logic [ChanW-1:0] a);
    expand_alpha = {1'b0, a} + {{ChanW{1'b0}}, a[ChanW-1]};
  endfunction

endpackage

/* hdl/mtob_blend.sv */
module mtob_blend (
  input  mtob_pkg::blend_req_t req_i,
  input  mtob_pkg::pix_t       tint_i,
  output mtob_pkg::blend_res_t res_o
);

  logic [mtob_pkg::ChanW:0]   cov_a;
  logic [mtob_pkg::ChanW:0]   over_a;
  logic signed [9:0]          cov_a_s;
  logic signed [8:0]          diff   [mtob_pkg::NumChan];
  logic signed [18:0]         prod   [mtob_pkg::NumChan];
  logic [mtob_pkg::ChanW-1:0] mask_c [mtob_pkg::NumChan];
  logic [16:0]                dprod  [mtob_pkg::NumChan];
  logic [mtob_pkg::ChanW:0]   sum    [mtob_pkg::NumChan];
  logic [mtob_pkg::ChanW-1:0] over_c [mtob_pkg::NumChan];

  assign cov_a   = mtob_pkg::expand_alpha(req_i.coverage);
  assign over_a  = mtob_pkg::expand_alpha(~req_i.src[mtob_pkg::AlphaIdx]);
  assign cov_a_s = $signed({1'b0, cov_a});

  always_comb begin
    for (int i = 0; i < mtob_pkg::NumChan; i++) begin
      diff[i]   = $signed({1'b0, tint_i[i]}) - $signed({1'b0, req_i.dst[i]});
      prod[i]   = diff[i] * cov_a_s;
      mask_c[i] = req_i.dst[i] + prod[i][15:8];
      dprod[i]  = req_i.dst[i] * over_a;
      sum[i]    = {1'b0, req_i.src[i]} + dprod[i][16:8];
      over_c[i] = sum[i][mtob_pkg::ChanW] ? mtob_pkg::ChanMax : sum[i][mtob_pkg::ChanW-1:0];
    end
  end

  always_comb begin
    res_o.pix     = req_i.dst;
    res_o.changed = 1'b1;
    unique case (req_i.mode)
      mtob_pkg::MODE_MASK: begin
        if (tint_i[mtob_pkg::AlphaIdx] == '0) begin
          res_o.changed = 1'b0;
        end else begin
          for (int i = 0; i < mtob_pkg::NumChan; i++) res_o.pix[i] = mask_c[i];
        end
      end
      mtob_pkg::MODE_OVER: begin
        for (int i = 0; i < mtob_pkg::NumChan; i++) res_o.pix[i] = over_c[i];
      end
      default: res_o.pix = req_i.dst;
    endcase
  end

endmodule

/* hdl/mask_tint_and_over_blend_unit.sv */
// Per-pixel blend unit for a blitter pixel stream.
// The s_axis channel takes one pixel request per cycle unless stalled: tuser
// selects the mode (0 tints the destination through the coverage byte, 1
// composites a premultiplied source over the destination). The m_axis channel
// returns one blended pixel per request, in order, with tuser set when the pixel was
// blended and clear when the destination passed through untouched.
// The config channel writes the tint color and the opacity; it is always ready
// and should only be written while no request is in flight.
// An accepted request is held in the input register, and its result is
// presented from the result register; the unit sustains one pixel per cycle
// while the receiver does not stall. The rate is set by the input register and
// the result register with one pass of per-channel multiply logic between them.
// The opacity-scaled tint is held in its own register, refreshed every cycle.
// Reset empties both pipeline registers, sets the tint to opaque black and the
// opacity to full. When the receiver stalls, the result holds on m_axis, the
// input register can still take one more request, and then s_axis_tready drops.
module mask_tint_and_over_blend_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Fields from bit 0: coverage, src_red, src_green, src_blue, src_alpha,
  // dst_red, dst_green, dst_blue, dst_alpha.
  input  logic [mtob_pkg::InDataW-1:0]         s_axis_tdata,
  // Fields from bit 0: mode.
  input  logic                                 s_axis_tuser,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // Fields from bit 0: out_red, out_green, out_blue, out_alpha.
  output logic [mtob_pkg::OutDataW-1:0]        m_axis_tdata,
  // Fields from bit 0: changed.
  output logic                                 m_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mtob_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [mtob_pkg::ChanW-1:0]           cfg_data_i
);

  mtob_pkg::pix_t                tint_q;
  mtob_pkg::pix_t                tint_scaled_d;
  mtob_pkg::pix_t                tint_scaled_q;
  logic [mtob_pkg::ChanW-1:0]    opacity_q;
  logic [15:0]                   scale_prod [mtob_pkg::NumChan];

  mtob_pkg::blend_req_t          req_d;
  mtob_pkg::blend_req_t          req_q;
  logic                          req_valid_q;
  mtob_pkg::blend_res_t          res_d;
  mtob_pkg::blend_res_t          res_q;
  logic                          res_valid_q;
  logic                          res_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tint_q    <= mtob_pkg::TintReset;
      opacity_q <= mtob_pkg::OpacityNone;
    end else if (cfg_valid_i) begin
      unique case (mtob_pkg::cfg_idx_e'(cfg_index_i))
        mtob_pkg::CFG_TINT_RED:   tint_q[0] <= cfg_data_i;
        mtob_pkg::CFG_TINT_GREEN: tint_q[1] <= cfg_data_i;
        mtob_pkg::CFG_TINT_BLUE:  tint_q[2] <= cfg_data_i;
        mtob_pkg::CFG_TINT_ALPHA: tint_q[3] <= cfg_data_i;
        mtob_pkg::CFG_OPACITY:    opacity_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < mtob_pkg::NumChan; i++) begin
      scale_prod[i]    = tint_q[i] * opacity_q;
      tint_scaled_d[i] = (opacity_q == mtob_pkg::OpacityNone) ? tint_q[i] : scale_prod[i][15:8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tint_scaled_q <= mtob_pkg::TintReset;
    end else begin
      tint_scaled_q <= tint_scaled_d;
    end
  end

  assign res_ready     = !res_valid_q || m_axis_tready;
  assign s_axis_tready = !req_valid_q || res_ready;

  always_comb begin
    req_d.mode     = mtob_pkg::mode_e'(s_axis_tuser);
    req_d.coverage = s_axis_tdata[7:0];
    for (int i = 0; i < mtob_pkg::NumChan; i++) begin
      req_d.src[i] = s_axis_tdata[8*i+8 +: 8];
      req_d.dst[i] = s_axis_tdata[8*i+40 +: 8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      req_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      req_q <= req_d;
    end
  end

  mtob_blend u_blend (
    .req_i  (req_q),
    .tint_i (tint_scaled_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_ready) begin
      res_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && req_valid_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = res_q.pix;
  assign m_axis_tuser  = res_q.changed;

endmodule

/* hdl/mtob_checker.sv */
module mtob_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [mtob_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready
);

  // A stalled result must hold its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("Stalled result changed.");

  // Reset leaves no result pending.
  assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("Result valid during reset.");

  // A fresh result follows an accepted request through the input and result registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("Result appeared without a request.");

  // The input side only pushes back while the output side is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("Input stalled without output backpressure.");

endmodule

bind mask_tint_and_over_blend_unit mtob_checker u_mtob_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

/* test/mask_tint_and_over_blend_unit_tb.sv */
`timescale 1ns / 1ps

module mask_tint_and_over_blend_unit_tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PixelTarget = 550;
  localparam int unsigned CalmFrom = 490;

  typedef enum logic {
    ROW_CFG,
    ROW_PIX
  } row_kind_e;

  typedef struct {
    row_kind_e            kind;
    mtob_pkg::cfg_idx_e   idx;
    logic [7:0]           val;
    mtob_pkg::mode_e      mode;
    logic [7:0]           cov;
    mtob_pkg::pix_t       src;
    mtob_pkg::pix_t       dst;
    logic                 typed;
    mtob_pkg::blend_res_t want;
  } plan_row_t;

  logic                          clk_i;
  logic                          rst_ni = 1'b0;
  logic [mtob_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic                          s_axis_tuser = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [mtob_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          m_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [mtob_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [mtob_pkg::ChanW-1:0]    cfg_data_i = '0;

  mtob_pkg::pix_t       tint_q = mtob_pkg::TintReset;
  logic [7:0]           opacity_q = mtob_pkg::OpacityNone;
  mtob_pkg::blend_res_t blend_exp_q[$];
  plan_row_t            plan[$];
  int unsigned          mismatches = 0;
  int unsigned          pixels_sent = 0;
  int unsigned          cycles = 0;
  int unsigned          stall_left = 0;
  bit                   calm = 1'b0;
  string                chan_name[mtob_pkg::NumChan] = '{"red", "green", "blue", "alpha"};

  mask_tint_and_over_blend_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic mtob_pkg::pix_t px(input int unsigned r, input int unsigned g,
                                        input int unsigned b, input int unsigned a);
    px = {8'(a), 8'(b), 8'(g), 8'(r)};
  endfunction

  function automatic plan_row_t cfg_row(input mtob_pkg::cfg_idx_e idx,
                                        input int unsigned val);
    plan_row_t row;
    row = '{kind: ROW_CFG, idx: idx, val: 8'(val), mode: mtob_pkg::MODE_MASK, cov: '0,
            src: '0, dst: '0, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic plan_row_t pix_row(input mtob_pkg::mode_e mode, input int unsigned cov,
                                        input mtob_pkg::pix_t src, input mtob_pkg::pix_t dst,
                                        input logic typed, input mtob_pkg::pix_t want_pix,
                                        input logic want_changed);
    plan_row_t row;
    row = '{kind: ROW_PIX, idx: mtob_pkg::CFG_TINT_RED, val: '0, mode: mode, cov: 8'(cov),
            src: src, dst: dst, typed: typed, want: '{want_pix, want_changed}};
    return row;
  endfunction

  // Expected blend of one pixel under the current tint and opacity.
  function automatic mtob_pkg::blend_res_t blend_predict(input mtob_pkg::mode_e mode,
                                                         input logic [7:0] cov,
                                                         input mtob_pkg::pix_t src,
                                                         input mtob_pkg::pix_t dst);
    mtob_pkg::blend_res_t res;
    int unsigned          tint[mtob_pkg::NumChan];
    int unsigned          f, k, d, sum;
    res.changed = 1'b1;
    if (mode == mtob_pkg::MODE_MASK) begin
      for (int c = 0; c < mtob_pkg::NumChan; c++) begin
        tint[c] = tint_q[c];
        if (opacity_q != mtob_pkg::OpacityNone) tint[c] = (tint[c] * opacity_q) >> 8;
      end
      if (tint[mtob_pkg::AlphaIdx] == 0) begin
        res.pix = dst;
        res.changed = 1'b0;
      end else begin
        f = cov + (cov >> 7);
        for (int c = 0; c < mtob_pkg::NumChan; c++) begin
          d = dst[c];
          res.pix[c] = 8'((tint[c] * f + d * (256 - f)) >> 8);
        end
      end
    end else begin
      k = 255 - src[mtob_pkg::AlphaIdx];
      f = k + (k >> 7);
      for (int c = 0; c < mtob_pkg::NumChan; c++) begin
        d = dst[c];
        sum = src[c] + ((d * f) >> 8);
        res.pix[c] = (sum > 255) ? 8'd255 : 8'(sum);
      end
    end
    return res;
  endfunction

  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 5))
      0: random_byte = 8'd0;
      1: random_byte = 8'd255;
      2: random_byte = ($urandom_range(0, 1) != 0) ? 8'd1 : 8'd254;
      default: random_byte = 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (blend_exp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input mtob_pkg::cfg_idx_e idx, input logic [7:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == mtob_pkg::CFG_OPACITY) opacity_q = val;
    else tint_q[idx] = val;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_pixel(input mtob_pkg::mode_e mode, input logic [7:0] cov,
                            input mtob_pkg::pix_t src, input mtob_pkg::pix_t dst,
                            input logic typed, input mtob_pkg::blend_res_t want);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {dst, src, cov};
    do @(posedge clk_i); while (!s_axis_tready);
    blend_exp_q.push_back(typed ? want : blend_predict(mode, cov, src, dst));
    pixels_sent++;
  endtask

  initial begin
    plan_row_t          row;
    mtob_pkg::cfg_idx_e idx;
    mtob_pkg::mode_e    mode;
    logic [7:0]         cov;
    mtob_pkg::pix_t     src, dst;
    int unsigned        n;

    // Reset values: black opaque tint, full opacity.
    plan.push_back(pix_row(mtob_pkg::MODE_MASK, 0, '0, px(12, 34, 56, 78), 1,
                           px(12, 34, 56, 78), 1));
    plan.push_back(pix_row(mtob_pkg::MODE_MASK, 255, '0, px(200, 100, 50, 9), 1,
                           px(0, 0, 0, 255), 1));
    plan.push_back(pix_row(mtob_pkg::MODE_MASK, 128, '0, px(255, 255, 255, 255), 0, '0, 0));
    plan.push_back(pix_row(mtob_pkg::MODE_MASK, 127, px(255, 255, 255, 255), px(1, 2, 3, 4),
                           0, '0, 0));
    plan.push_back(pix_row(mtob_pkg::MODE_OVER, 255, px(255, 255, 255, 255),
                           px(255, 255, 255, 255), 1, px(255, 255, 255, 255), 1));
    plan.push_back(pix_row(mtob_pkg::MODE_OVER, 0, '0, px(255, 128, 7, 255), 1,
                           px(255, 128, 7, 255), 1));
    plan.push_back(pix_row(mtob_pkg::MODE_OVER, 0, px(200, 200, 200, 100),
                           px(255, 255, 255, 255), 0, '0, 0));
    plan.push_back(pix_row(mtob_pkg::MODE_OVER, 0, '0, '0, 1, '0, 1));
    plan.push_back(pix_row(mtob_pkg::MODE_OVER, 9, px(10, 20, 30, 128), px(90, 80, 70, 60),
                           0, '0, 0));
    // Zero opacity makes the tint transparent, so the destination passes through.
    plan.push_back(cfg_row(mtob_pkg::CFG_OPACITY, 0));
    plan.push_back(pix_row(mtob_pkg::MODE_MASK, 255, '0, px(5, 6, 7, 8), 1, px(5, 6, 7, 8), 0));
    plan.push_back(pix_row(mtob_pkg::MODE_OVER, 3, px(1, 2, 3, 4), px(250, 251, 252, 253),
                           0, '0, 0));
    plan.push_back(cfg_row(mtob_pkg::CFG_TINT_RED, 255));
    plan.push_back(cfg_row(mtob_pkg::CFG_TINT_GREEN, 255));
    plan.push_back(cfg_row(mtob_pkg::CFG_TINT_BLUE, 255));
    plan.push_back(cfg_row(mtob_pkg::CFG_OPACITY, 255));
    plan.push_back(pix_row(mtob_pkg::MODE_MASK, 255, '0, '0, 1, px(255, 255, 255, 255), 1));
    plan.push_back(pix_row(mtob_pkg::MODE_MASK, 0, '0, '0, 1, '0, 1));
    plan.push_back(cfg_row(mtob_pkg::CFG_TINT_ALPHA, 0));
    plan.push_back(pix_row(mtob_pkg::MODE_MASK, 200, '0, px(9, 8, 7, 6), 1, px(9, 8, 7, 6), 0));
    plan.push_back(cfg_row(mtob_pkg::CFG_TINT_ALPHA, 1));
    plan.push_back(cfg_row(mtob_pkg::CFG_OPACITY, 254));
    plan.push_back(pix_row(mtob_pkg::MODE_MASK, 255, '0, px(3, 3, 3, 3), 1, px(3, 3, 3, 3), 0));
    plan.push_back(cfg_row(mtob_pkg::CFG_TINT_ALPHA, 255));
    plan.push_back(cfg_row(mtob_pkg::CFG_TINT_GREEN, 128));
    plan.push_back(cfg_row(mtob_pkg::CFG_TINT_BLUE, 1));
    plan.push_back(cfg_row(mtob_pkg::CFG_OPACITY, 128));
    plan.push_back(pix_row(mtob_pkg::MODE_MASK, 1, '0, px(255, 0, 128, 64), 0, '0, 0));
    plan.push_back(pix_row(mtob_pkg::MODE_MASK, 254, '0, px(255, 0, 128, 64), 0, '0, 0));
    plan.push_back(pix_row(mtob_pkg::MODE_MASK, 128, '0, px(0, 255, 0, 255), 0, '0, 0));
    plan.push_back(cfg_row(mtob_pkg::CFG_OPACITY, 1));
    plan.push_back(pix_row(mtob_pkg::MODE_MASK, 77, '0, px(11, 22, 33, 44), 1,
                           px(11, 22, 33, 44), 0));
    plan.push_back(cfg_row(mtob_pkg::CFG_OPACITY, 2));
    plan.push_back(pix_row(mtob_pkg::MODE_MASK, 255, '0, px(11, 22, 33, 44), 0, '0, 0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_CFG) cfg_write(row.idx, row.val);
      else send_pixel(row.mode, row.cov, row.src, row.dst, row.typed, row.want);
    end

    while (pixels_sent < PixelTarget) begin
      idx = idx.first();
      repeat (idx.num()) begin
        if ($urandom_range(0, 1) != 0) cfg_write(idx, random_byte());
        idx = idx.next();
      end
      n = $urandom_range(5, 40);
      repeat (n) begin
        calm = (pixels_sent >= CalmFrom);
        mode = ($urandom_range(0, 1) != 0) ? mtob_pkg::MODE_OVER : mtob_pkg::MODE_MASK;
        cov = random_byte();
        for (int c = 0; c < mtob_pkg::NumChan; c++) begin
          src[c] = random_byte();
          dst[c] = random_byte();
        end
        send_pixel(mode, cov, src, dst, 1'b0, '0);
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 17);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : result_check
    mtob_pkg::blend_res_t want;
    mtob_pkg::pix_t       got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (blend_exp_q.size() == 0) begin
        $display("%0t: result with nothing expected: pixel %h changed %b",
                 $time, got, m_axis_tuser);
        mismatches++;
      end else begin
        want = blend_exp_q.pop_front();
        for (int c = 0; c < mtob_pkg::NumChan; c++) begin
          if (got[c] !== want.pix[c]) begin
            $display("%0t: %s expected %0d actual %0d", $time, chan_name[c],
                     want.pix[c], got[c]);
            mismatches++;
          end
        end
        if (m_axis_tuser !== want.changed) begin
          $display("%0t: changed expected %b actual %b", $time, want.changed, m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
